[design/tdpt_pkg.sv]
package tdpt_pkg;

  // Width of the candidate and tested_value fields on the channels
  localparam int unsigned DATA_W      = 32;
  // Width the candidate is classified at (upper candidate bits dropped)
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam value_t FIRST_DIVISOR = value_t'(2);

  typedef enum logic [1:0] {
    VERDICT_NEITHER   = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_COMPOSITE = 2'd2
  } verdict_t;

  // Sequencer -> divider
  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  // Divider -> sequencer
  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

endpackage

[design/tdpt_in_if.sv]
interface tdpt_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdpt_pkg::DATA_W-1:0]  candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

[design/tdpt_out_if.sv]
interface tdpt_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   verdict;
  logic [tdpt_pkg::DATA_W-1:0]  tested_value;

  modport source (output valid, output verdict, output tested_value, input ready);
  modport sink   (input valid, input verdict, input tested_value, output ready);
endinterface

[design/tdpt_divider.sv]
module tdpt_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  tdpt_pkg::div_req_t req,
  output tdpt_pkg::div_rsp_t rsp
);
  import tdpt_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  value_t           quo_r, quo_nxt;
  value_t           rem_r, rem_nxt;
  value_t           div_r, div_nxt;

  logic [VALUE_WIDTH:0] trial;
  logic [VALUE_WIDTH:0] diff;
  logic                 fits;

  // one restoring shift-subtract step per cycle
  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (busy_r) begin
      rem_nxt = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      cnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("done without a running division");
`endif

endmodule

[design/trial_division_prime_test.sv]
// Channel   Dir  Payload                          Transfer
// in_chan   in   candidate[31:0]                  valid & ready
// out_chan  out  verdict[1:0], tested_value[31:0] valid & ready
//
// Zero and one: result is offered the cycle after the transaction.
// Otherwise each divisor tried takes a launch, 32 shift-subtract steps in the
// shared divider and a response; worst case near 2^16 divisors for a full
// 32-bit prime.
// Reset (rst_n low at a clock edge) returns sequencer and divider to idle.
// in_chan.ready is low from a transaction until its result is taken; the result
// holds in output registers while out_chan.ready is low.
module trial_division_prime_test (
  input logic              clk,
  input logic              rst_n,
  tdpt_in_if.sink          in_chan,
  tdpt_out_if.source       out_chan
);
  import tdpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,  // waiting for a candidate
    S_DIV  = 3'b010,  // divider running on n_r / d_r
    S_OUT  = 3'b100   // result offered
  } state_t;

  state_t   state_r, state_nxt;
  value_t   n_r, n_nxt;          // value under test
  value_t   d_r, d_nxt;          // current trial divisor
  verdict_t verdict_r, verdict_nxt;
  logic     start_r, start_nxt;

  logic     in_accept;
  value_t   in_value;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_accept = in_chan.valid && in_chan.ready;
  // candidate is classified at VALUE_WIDTH bits
  assign in_value  = value_t'(in_chan.candidate);

  tdpt_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign div_req.start    = start_r;
  assign div_req.dividend = n_r;
  assign div_req.divisor  = d_r;

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    d_nxt       = d_r;
    verdict_nxt = verdict_r;
    start_nxt   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          n_nxt = in_value;
          d_nxt = FIRST_DIVISOR;
          if (in_value < FIRST_DIVISOR) begin
            // zero and one are neither prime nor composite; no search
            verdict_nxt = VERDICT_NEITHER;
            state_nxt   = S_OUT;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          // d > n/d: past the square-root bound, no divisor exists
          priority if (d_r > div_rsp.quotient) begin
            verdict_nxt = VERDICT_PRIME;
            state_nxt   = S_OUT;
          end else if (div_rsp.remainder == '0) begin
            verdict_nxt = VERDICT_COMPOSITE;
            state_nxt   = S_OUT;
          end else begin
            d_nxt     = d_r + 1'b1;
            start_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (out_chan.valid && out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    verdict_r <= verdict_nxt;
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = (state_r == S_OUT);
  assign out_chan.verdict      = verdict_r;
  assign out_chan.tested_value = DATA_W'(n_r);

`ifndef ASSERT_OFF
  a_neither_small: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (verdict_r == VERDICT_NEITHER)) |-> (n_r < FIRST_DIVISOR))
    else $error("neither verdict on a value above one");

  a_composite_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (verdict_r == VERDICT_COMPOSITE))
      |-> ((d_r >= FIRST_DIVISOR) && (d_r < n_r)))
    else $error("composite verdict with a bad divisor");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider response outside the search");
`endif

endmodule

[sim/trial_division_prime_test_test.sv]
module trial_division_prime_test_test;
  import tdpt_pkg::*;

  // Random candidates whose search would try more divisors than this are
  // redrawn, which keeps each transaction short.
  localparam int unsigned STEP_CAP      = 200;
  localparam int unsigned RANDOM_ITEMS  = 80;
  // Nothing stays in flight once the last result is taken, so only a short tail.
  localparam int unsigned DRAIN_CYCLES  = 50;
  // Worst legal run: 80 random items * 200 divisors plus about 2,800 divisors for
  // the directed ones, plus stalls. Allow several times that.
  localparam longint unsigned RUN_LIMIT = 80_000_000;

  typedef struct {
    verdict_t             verdict;
    logic [DATA_W-1:0]    value;
  } verdict_rec_t;

  logic clk;
  logic rst_n;

  tdpt_in_if  in_chan ();
  tdpt_out_if out_chan ();

  trial_division_prime_test u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Candidates waiting to be driven, and verdicts waiting to come back.
  logic [DATA_W-1:0] candidates_q[$];
  verdict_rec_t      verdicts_q[$];

  int unsigned err_count;
  int unsigned accepted_count;
  int unsigned total_count;

  // Handshake outcomes sampled at the rising edge, consumed at the falling edge.
  bit          in_fire;
  bit          out_fire;
  // Idle cycles still to be spent by each side, and calm stretches (no idling).
  int unsigned in_gap;
  int unsigned out_stall;
  int unsigned in_calm;
  int unsigned out_calm;

  verdict_rec_t mon_rec;
  int unsigned  mon_steps;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Trial division up to the integer square root. The bound is checked as
  // d <= n / d so nothing overflows at full range. Also returns how many
  // divisors were tried, which sizes the time the block will spend.
  function automatic void classify(input logic [DATA_W-1:0] raw, output verdict_t verdict,
                                   output int unsigned steps);
    logic [63:0] n;
    logic [63:0] d;
    bit          found;
    n     = 64'(value_t'(raw));  // bits above VALUE_WIDTH are dropped
    d     = 64'(FIRST_DIVISOR);
    found = 1'b0;
    steps = 0;
    if (n < d) begin
      // zero and one: no search at all
      verdict = VERDICT_NEITHER;
      return;
    end
    while (d <= n / d) begin
      steps++;
      if (n % d == 0) begin
        found = 1'b1;
        break;
      end
      d++;
    end
    verdict = found ? VERDICT_COMPOSITE : VERDICT_PRIME;
  endfunction

  // Idle cycles for one transaction: mostly a random draw, with runs of back-to-back traffic.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    err_count++;
  endtask

  // Monitor: sample both channels at the rising edge. A result is checked
  // against the oldest pending verdict; an accepted candidate queues a new one.
  always @(posedge clk) begin
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_n) begin
      in_fire  = in_chan.valid && in_chan.ready;
      out_fire = out_chan.valid && out_chan.ready;
      if (out_fire) begin
        if (verdicts_q.size() == 0) begin
          report($sformatf("result with nothing pending: verdict %0d value %h",
                           out_chan.verdict, out_chan.tested_value));
        end else begin
          mon_rec = verdicts_q.pop_front();
          if (out_chan.verdict !== mon_rec.verdict)
            report($sformatf("verdict %0d, want %0d for value %h",
                             out_chan.verdict, mon_rec.verdict, mon_rec.value));
          if (out_chan.tested_value !== mon_rec.value)
            report($sformatf("tested_value %h, want %h",
                             out_chan.tested_value, mon_rec.value));
        end
        out_stall = draw_wait(out_calm);
      end
      if (in_fire) begin
        classify(in_chan.candidate, mon_rec.verdict, mon_steps);
        mon_rec.value = DATA_W'(value_t'(in_chan.candidate));
        verdicts_q.push_back(mon_rec);
        accepted_count++;
      end
    end
  end

  // Driver: change inputs at the falling edge only. valid holds until the
  // transaction goes through; with no gap the next candidate follows at once.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_chan.valid || in_fire) begin
        if (in_gap > 0) begin
          in_chan.valid     <= 1'b0;
          in_chan.candidate <= $urandom();  // idle noise on the bus
          in_gap--;
        end else if (candidates_q.size() > 0) begin
          in_chan.valid     <= 1'b1;
          in_chan.candidate <= candidates_q.pop_front();
          in_gap = draw_wait(in_calm);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
      // Result side: ready drops for a drawn stall after each result taken.
      if (out_stall > 0) begin
        out_chan.ready <= 1'b0;
        out_stall--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] pick;
    verdict_t          pick_verdict;
    int unsigned       pick_steps;

    clk               = 1'b0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.candidate = '0;
    out_chan.ready    = 1'b0;
    err_count         = 0;
    accepted_count    = 0;
    in_gap            = 0;
    out_stall         = 0;
    in_calm           = 0;
    out_calm          = 0;

    // Directed: zero and one (no search), smallest primes and composites,
    // squares of primes (divisor lands exactly on the root bound), primes just
    // around 2^16 and 2^20, a semiprime with two close factors, and full-range
    // values where the d <= n / d bound must not overflow.
    candidates_q = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
      32'd63001,      // 251 * 251
      32'd65521, 32'd65537,
      32'd1048573,    // prime below 2^20
      32'd1052651,    // 1021 * 1031
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h5555_5555,
      32'hAAAA_AAAA, 32'h7FFF_FFFE
    };

    // Random: full-range values, 16-bit values (where primes are cheap to
    // reach), tiny values, products with a small factor, and 20-bit values.
    // Anything whose search would run long is redrawn.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      do begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: pick = $urandom();
          4, 5, 6:    pick = $urandom_range(0, 65535);
          7:          pick = $urandom_range(0, 15);
          8:          pick = DATA_W'($urandom_range(2, 150) * $urandom_range(2, 28_000_000));
          default:    pick = $urandom_range(0, 1048575);
        endcase
        classify(pick, pick_verdict, pick_steps);
      end while (pick_steps > STEP_CAP);
      candidates_q.push_back(pick);
    end
    total_count = candidates_q.size();

    // Synchronous reset, released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every candidate went in and every verdict came back.
    do @(negedge clk);
    while (accepted_count < total_count || verdicts_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("trial_division_prime_test_test: done, clean");
    end else begin
      $display("trial_division_prime_test_test: done, errors");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a runaway search ends the run here.
  initial begin
    #(RUN_LIMIT);
    $display("trial_division_prime_test_test: done, errors");
    $finish;
  end

endmodule
